// ===== rtl/blob_bounding_box_grower_assert.svh =====
// Assertion macros for the blob bounding-box grower.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef BLOB_BOUNDING_BOX_GROWER_ASSERT_SVH
`define BLOB_BOUNDING_BOX_GROWER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBG_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bbg_pkg.sv =====
// Shared constants of the blob bounding-box grower: defaults, field widths and
// configuration register indexes. Depends on nothing.
package bbg_pkg;

    // Default sizing of the box table and the coordinates.
    localparam int MAX_BOXES_DEF  = 16;
    localparam int COORD_BITS_DEF = 11;

    // Configuration field widths.
    localparam int PAD_W    = 8;
    localparam int REGION_W = 5;

    // Configuration write channel.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PADDING     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REGIONS = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [PAD_W-1:0]    PADDING_RST     = 8'd0;
    localparam logic [REGION_W-1:0] MAX_REGIONS_RST = 5'd16;

endpackage

// ===== rtl/bbg_axis.sv =====
// One axis of the shared box unit: centre-distance test and union of extents.
// Depends on bbg_pkg for the padding width.
module bbg_axis #(
    parameter int COORD_BITS = bbg_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] a_lo,
    input  logic [COORD_BITS:0]   a_hi,
    input  logic [COORD_BITS-1:0] b_lo,
    input  logic [COORD_BITS:0]   b_hi,
    input  logic [COORD_BITS:0]   b_sum,
    input  logic [((COORD_BITS + 1 > bbg_pkg::PAD_W + 1) ?
                   COORD_BITS + 1 : bbg_pkg::PAD_W + 1) - 1:0] b_span,
    output logic [COORD_BITS:0]   a_sum,
    output logic [COORD_BITS:0]   a_span,
    output logic                  hit,
    output logic [COORD_BITS-1:0] u_lo,
    output logic [COORD_BITS:0]   u_hi
);
    import bbg_pkg::*;

    localparam int SUM_W  = COORD_BITS + 1;
    localparam int SPAN_W = (COORD_BITS + 1 > PAD_W + 1) ? COORD_BITS + 1 : PAD_W + 1;

    logic signed [SUM_W:0] diff;
    logic [SUM_W-1:0]      centre_gap;
    logic [SPAN_W:0]       tot;

    // Doubled centre and width of operand A.
    assign a_sum  = {1'b0, a_lo} + a_hi;
    assign a_span = a_hi - {1'b0, a_lo};

    // The centres are close enough when their distance is below half the summed widths.
    assign diff       = $signed({1'b0, a_sum}) - $signed({1'b0, b_sum});
    assign centre_gap = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
    assign tot        = (SPAN_W + 1)'(a_span) + (SPAN_W + 1)'(b_span);
    assign hit        = ((SPAN_W + 1)'(centre_gap) < tot);

    // Union of the two extents.
    assign u_lo = (a_lo < b_lo) ? a_lo : b_lo;
    assign u_hi = (a_hi > b_hi) ? a_hi : b_hi;

endmodule

// ===== rtl/bbg_store.sv =====
// Box table of the blob bounding-box grower: one write port and one registered
// read port with write-first forwarding. Depends on bbg_pkg for the default sizes.
module bbg_store #(
    parameter int MAX_BOXES  = bbg_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bbg_pkg::COORD_BITS_DEF
) (
    input  logic                                            clk,
    input  logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1) - 1:0] rd_idx,
    input  logic                                            wr_en,
    input  logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1) - 1:0] wr_idx,
    input  logic [COORD_BITS-1:0]                           wr_left,
    input  logic [COORD_BITS-1:0]                           wr_top,
    input  logic [COORD_BITS:0]                             wr_right,
    input  logic [COORD_BITS:0]                             wr_bottom,
    output logic [COORD_BITS-1:0]                           rd_left,
    output logic [COORD_BITS-1:0]                           rd_top,
    output logic [COORD_BITS:0]                             rd_right,
    output logic [COORD_BITS:0]                             rd_bottom
);

    logic [COORD_BITS-1:0] left_mem   [MAX_BOXES];
    logic [COORD_BITS-1:0] top_mem    [MAX_BOXES];
    logic [COORD_BITS:0]   right_mem  [MAX_BOXES];
    logic [COORD_BITS:0]   bottom_mem [MAX_BOXES];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_idx]   <= wr_left;
            top_mem[wr_idx]    <= wr_top;
            right_mem[wr_idx]  <= wr_right;
            bottom_mem[wr_idx] <= wr_bottom;
        end
    end

    // Registered read; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == rd_idx))
        begin
            rd_left   <= wr_left;
            rd_top    <= wr_top;
            rd_right  <= wr_right;
            rd_bottom <= wr_bottom;
        end
        else
        begin
            rd_left   <= left_mem[rd_idx];
            rd_top    <= top_mem[rd_idx];
            rd_right  <= right_mem[rd_idx];
            rd_bottom <= bottom_mem[rd_idx];
        end
    end

endmodule

// ===== rtl/blob_bounding_box_grower.sv =====
// Top level of the blob bounding-box grower: sequencer, configuration and results.
// Depends on bbg_pkg, bbg_store, bbg_axis and blob_bounding_box_grower_assert.svh.
//
// Usage. Pixels arrive in raster order on pixel_x, pixel_y, foreground and
// end_of_frame; a transaction is taken when start is high and busy is low.
// Configuration (padding, max_regions) is written on the cfg_valid/cfg_ready
// channel by cfg_index and cfg_data; the user must write it only while the block
// is idle, which the block itself does not enforce. cfg_ready is always high.
// A background pixel is not scanned; a foreground pixel is scanned against every
// opened box, one table entry per cycle through the shared compare unit and the
// single read port of the box table. On the end-of-frame pixel the merge passes
// follow, then the survivors are emitted. Each result stands on the box ports
// for one cycle, marked by result_valid, and is registered from the read data of
// its table entry; the receiver cannot stall and need not.
// A frame with no boxes yields one result with no_boxes and last_box set.
// Reset empties the table and restores padding 0 and max_regions 16.
`include "blob_bounding_box_grower_assert.svh"

module blob_bounding_box_grower #(
    parameter int MAX_BOXES  = bbg_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bbg_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [COORD_BITS-1:0]           pixel_x,
    input  logic [COORD_BITS-1:0]           pixel_y,
    input  logic                            foreground,
    input  logic                            end_of_frame,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bbg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            result_valid,
    output logic [COORD_BITS-1:0]           box_left,
    output logic [COORD_BITS-1:0]           box_top,
    output logic [COORD_BITS:0]             box_width,
    output logic [COORD_BITS:0]             box_height,
    output logic [$clog2(MAX_BOXES + 1)-1:0] box_count,
    output logic                            last_box,
    output logic                            no_boxes
);
    import bbg_pkg::*;

    localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int SUM_W  = COORD_BITS + 1;
    localparam int SPAN_W = (COORD_BITS + 1 > PAD_W + 1) ? COORD_BITS + 1 : PAD_W + 1;
    localparam int LIM_W  = (CNT_W > REGION_W) ? CNT_W : REGION_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GROW  = 3'd1;
    localparam logic [2:0] S_MLOAD = 3'd2;
    localparam logic [2:0] S_MSCAN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      open_reg, open_next;
    logic [CNT_W-1:0]      live_reg, live_next;
    logic [CNT_W-1:0]      emitted_reg, emitted_next;
    logic                  found_reg, found_next;
    logic [MAX_BOXES-1:0]  valid_reg, valid_next;
    logic [PAD_W-1:0]      padding_reg;
    logic [REGION_W-1:0]   max_regions_reg;

    // Latched pixel.
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic                  fg_reg, eof_reg;

    // Running union and frozen centre/width of the box under merge.
    logic [COORD_BITS-1:0] run_l_reg, run_l_next, run_t_reg, run_t_next;
    logic [COORD_BITS:0]   run_r_reg, run_r_next, run_b_reg, run_b_next;
    logic [SUM_W-1:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic [COORD_BITS:0]   wx_reg, wx_next, wy_reg, wy_next;

    // Result register.
    logic                  res_valid_reg, res_valid_next;
    logic [COORD_BITS-1:0] res_left_next, res_top_next;
    logic [COORD_BITS:0]   res_width_next, res_height_next;
    logic                  res_last_next, res_none_next;
    logic [COORD_BITS-1:0] res_left_reg, res_top_reg;
    logic [COORD_BITS:0]   res_width_reg, res_height_reg;
    logic [CNT_W-1:0]      res_count_reg;
    logic                  res_last_reg, res_none_reg;

    // Box table port signals.
    logic [IDX_W-1:0]      rd_idx, wr_idx;
    logic                  wr_en;
    logic [COORD_BITS-1:0] wr_left, wr_top, rd_left, rd_top;
    logic [COORD_BITS:0]   wr_right, wr_bottom, rd_right, rd_bottom;

    // Shared unit signals.
    logic [COORD_BITS-1:0] bx_lo, by_lo, ux_lo, uy_lo;
    logic [COORD_BITS:0]   bx_hi, by_hi, ux_hi, uy_hi;
    logic [SUM_W-1:0]      bx_sum, by_sum;
    logic [SPAN_W-1:0]     bx_span, by_span;
    logic [COORD_BITS:0]   ax_sum, ay_sum, ax_span, ay_span;
    logic                  hit_x, hit_y;

    logic                  accept;
    logic                  in_merge;
    logic [IDX_W-1:0]      k_idx;
    logic                  k_live;
    logic                  room;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_merge  = (state_reg == S_MSCAN);
    assign k_idx     = k_reg[IDX_W-1:0];
    assign k_live    = (k_reg < open_reg);
    assign room      = (LIM_W'(open_reg) < LIM_W'(max_regions_reg)) &&
                       (open_reg < CNT_W'(MAX_BOXES));

    // Box table; the read address follows the scan pointer's next value.
    assign rd_idx = (k_next < CNT_W'(MAX_BOXES)) ? k_next[IDX_W-1:0] : '0;

    bbg_store #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .clk       (clk),
        .rd_idx    (rd_idx),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_left   (wr_left),
        .wr_top    (wr_top),
        .wr_right  (wr_right),
        .wr_bottom (wr_bottom),
        .rd_left   (rd_left),
        .rd_top    (rd_top),
        .rd_right  (rd_right),
        .rd_bottom (rd_bottom)
    );

    // Operand B: the pixel with its padding while growing, the running box while merging.
    always_comb
    begin
        if (in_merge)
        begin
            bx_lo   = run_l_reg;
            bx_hi   = run_r_reg;
            bx_sum  = sx_reg;
            bx_span = SPAN_W'(wx_reg);
            by_lo   = run_t_reg;
            by_hi   = run_b_reg;
            by_sum  = sy_reg;
            by_span = SPAN_W'(wy_reg);
        end
        else
        begin
            bx_lo   = x_reg;
            bx_hi   = {1'b0, x_reg};
            bx_sum  = {x_reg, 1'b0};
            bx_span = SPAN_W'({padding_reg, 1'b0});
            by_lo   = y_reg;
            by_hi   = {1'b0, y_reg};
            by_sum  = {y_reg, 1'b0};
            by_span = SPAN_W'({padding_reg, 1'b0});
        end
    end

    bbg_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_x (
        .a_lo   (rd_left),
        .a_hi   (rd_right),
        .b_lo   (bx_lo),
        .b_hi   (bx_hi),
        .b_sum  (bx_sum),
        .b_span (bx_span),
        .a_sum  (ax_sum),
        .a_span (ax_span),
        .hit    (hit_x),
        .u_lo   (ux_lo),
        .u_hi   (ux_hi)
    );

    bbg_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_y (
        .a_lo   (rd_top),
        .a_hi   (rd_bottom),
        .b_lo   (by_lo),
        .b_hi   (by_hi),
        .b_sum  (by_sum),
        .b_span (by_span),
        .a_sum  (ay_sum),
        .a_span (ay_span),
        .hit    (hit_y),
        .u_lo   (uy_lo),
        .u_hi   (uy_hi)
    );

    // Sequencer: grow scan, merge passes, emission.
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        open_next       = open_reg;
        live_next       = live_reg;
        emitted_next    = emitted_reg;
        found_next      = found_reg;
        valid_next      = valid_reg;
        run_l_next      = run_l_reg;
        run_t_next      = run_t_reg;
        run_r_next      = run_r_reg;
        run_b_next      = run_b_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        wx_next         = wx_reg;
        wy_next         = wy_reg;
        wr_en           = 1'b0;
        wr_idx          = k_idx;
        wr_left         = ux_lo;
        wr_top          = uy_lo;
        wr_right        = ux_hi;
        wr_bottom       = uy_hi;
        res_valid_next  = 1'b0;
        res_left_next   = rd_left;
        res_top_next    = rd_top;
        res_width_next  = ax_span;
        res_height_next = ay_span;
        res_last_next   = 1'b0;
        res_none_next   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_GROW;
                    k_next     = '0;
                    found_next = 1'b0;
                end
            end

            S_GROW:
            begin
                if (!fg_reg || !k_live)
                begin
                    // End of scan: open a box if none took the pixel and there is room.
                    if (fg_reg && !found_reg && room)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = open_reg[IDX_W-1:0];
                        wr_left    = x_reg;
                        wr_top     = y_reg;
                        wr_right   = {1'b0, x_reg} + SUM_W'(1);
                        wr_bottom  = {1'b0, y_reg} + SUM_W'(1);
                        valid_next[open_reg[IDX_W-1:0]] = 1'b1;
                        open_next  = open_reg + CNT_W'(1);
                        live_next  = live_reg + CNT_W'(1);
                    end
                    k_next = '0;
                    i_next = '0;
                    state_next = eof_reg ? S_MLOAD : S_IDLE;
                end
                else
                begin
                    // Stretch every box whose padded extent holds the pixel.
                    if (valid_reg[k_idx] && hit_x && hit_y)
                    begin
                        wr_en      = 1'b1;
                        found_next = 1'b1;
                    end
                    k_next = k_reg + CNT_W'(1);
                end
            end

            S_MLOAD:
            begin
                if (!k_live)
                begin
                    k_next       = '0;
                    emitted_next = '0;
                    state_next   = (live_reg == '0) ? S_EMPTY : S_EMIT;
                end
                else if (!valid_reg[k_idx])
                begin
                    k_next = k_reg + CNT_W'(1);
                    i_next = k_reg + CNT_W'(1);
                end
                else
                begin
                    // Freeze the centre and width of box i for its whole pass.
                    run_l_next = rd_left;
                    run_t_next = rd_top;
                    run_r_next = rd_right;
                    run_b_next = rd_bottom;
                    sx_next    = ax_sum;
                    sy_next    = ay_sum;
                    wx_next    = ax_span;
                    wy_next    = ay_span;
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_MSCAN;
                end
            end

            S_MSCAN:
            begin
                if (!k_live)
                begin
                    // Pass done: store the grown box i and move to the next one.
                    wr_en      = 1'b1;
                    wr_idx     = i_reg[IDX_W-1:0];
                    wr_left    = run_l_reg;
                    wr_top     = run_t_reg;
                    wr_right   = run_r_reg;
                    wr_bottom  = run_b_reg;
                    i_next     = i_reg + CNT_W'(1);
                    k_next     = i_reg + CNT_W'(1);
                    state_next = S_MLOAD;
                end
                else
                begin
                    if (valid_reg[k_idx] && hit_x && hit_y)
                    begin
                        run_l_next        = ux_lo;
                        run_t_next        = uy_lo;
                        run_r_next        = ux_hi;
                        run_b_next        = uy_hi;
                        valid_next[k_idx] = 1'b0;
                        live_next         = live_reg - CNT_W'(1);
                    end
                    k_next = k_reg + CNT_W'(1);
                end
            end

            S_EMIT:
            begin
                if (!k_live)
                begin
                    valid_next = '0;
                    open_next  = '0;
                    live_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (valid_reg[k_idx])
                    begin
                        res_valid_next = 1'b1;
                        res_last_next  = ((emitted_reg + CNT_W'(1)) == live_reg);
                        emitted_next   = emitted_reg + CNT_W'(1);
                    end
                    k_next = k_reg + CNT_W'(1);
                end
            end

            S_EMPTY:
            begin
                res_valid_next  = 1'b1;
                res_left_next   = '0;
                res_top_next    = '0;
                res_width_next  = '0;
                res_height_next = '0;
                res_last_next   = 1'b1;
                res_none_next   = 1'b1;
                valid_next      = '0;
                open_next       = '0;
                live_next       = '0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            open_reg      <= '0;
            live_reg      <= '0;
            emitted_reg   <= '0;
            found_reg     <= 1'b0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            open_reg      <= open_next;
            live_reg      <= live_next;
            emitted_reg   <= emitted_next;
            found_reg     <= found_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            padding_reg     <= PADDING_RST;
            max_regions_reg <= MAX_REGIONS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PADDING:     padding_reg     <= cfg_data[PAD_W-1:0];
                REG_MAX_REGIONS: max_regions_reg <= cfg_data[REGION_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: the latched pixel, the merge operands and the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= pixel_x;
            y_reg   <= pixel_y;
            fg_reg  <= foreground;
            eof_reg <= end_of_frame;
        end
        run_l_reg <= run_l_next;
        run_t_reg <= run_t_next;
        run_r_reg <= run_r_next;
        run_b_reg <= run_b_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        wx_reg    <= wx_next;
        wy_reg    <= wy_next;
        if (res_valid_next)
        begin
            res_left_reg   <= res_left_next;
            res_top_reg    <= res_top_next;
            res_width_reg  <= res_width_next;
            res_height_reg <= res_height_next;
            res_count_reg  <= live_reg;
            res_last_reg   <= res_last_next;
            res_none_reg   <= res_none_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign box_left     = res_left_reg;
    assign box_top      = res_top_reg;
    assign box_width    = res_width_reg;
    assign box_height   = res_height_reg;
    assign box_count    = res_count_reg;
    assign last_box     = res_last_reg;
    assign no_boxes     = res_none_reg;

    // Checks on the sequencer and the result stream.
    `BBG_ASSERT(live_within_open, clk, rst_n, 1'b1, live_reg <= open_reg, "more live boxes than opened")
    `BBG_ASSERT(open_within_table, clk, rst_n, 1'b1, open_reg <= CNT_W'(MAX_BOXES), "box table overrun")
    `BBG_ASSERT_NEXT(accept_sets_busy, clk, rst_n, accept, busy, "transaction taken but block not busy")
    `BBG_ASSERT(empty_result_is_last, clk, rst_n, res_valid_reg && res_none_reg, res_last_reg && (res_count_reg == '0), "empty-frame result malformed")
    `BBG_ASSERT_NEXT(frame_end_clears, clk, rst_n, state_reg == S_EMPTY, (open_reg == '0) && (live_reg == '0) && (valid_reg == '0), "table not cleared at frame end")

endmodule
